[hw/rtl/bta_pkg.sv]
// ----------------------------------------------------------------------------
// bta_pkg: shared types and command codes of the first-fit allocator
// Holds the command codes from the controller to the datapath, and the
// command and status structs that join them.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int unsigned FieldWidth = 12;
  localparam int unsigned OpWidth    = 5;

  localparam logic [OpWidth-1:0] CMD_NOP    = 5'd0;
  localparam logic [OpWidth-1:0] CMD_CLR    = 5'd1;
  localparam logic [OpWidth-1:0] CMD_LOAD   = 5'd2;
  localparam logic [OpWidth-1:0] CMD_RD_AT  = 5'd3;
  localparam logic [OpWidth-1:0] CMD_A_STEP = 5'd4;
  localparam logic [OpWidth-1:0] CMD_A_TAKE = 5'd5;
  localparam logic [OpWidth-1:0] CMD_A_SPL1 = 5'd6;
  localparam logic [OpWidth-1:0] CMD_A_SPL2 = 5'd7;
  localparam logic [OpWidth-1:0] CMD_A_OK   = 5'd8;
  localparam logic [OpWidth-1:0] CMD_A_FAIL = 5'd9;
  localparam logic [OpWidth-1:0] CMD_F_REL  = 5'd10;
  localparam logic [OpWidth-1:0] CMD_RD_R   = 5'd11;
  localparam logic [OpWidth-1:0] CMD_R_ADD  = 5'd12;
  localparam logic [OpWidth-1:0] CMD_L_INIT = 5'd13;
  localparam logic [OpWidth-1:0] CMD_RD_L   = 5'd14;
  localparam logic [OpWidth-1:0] CMD_L_ADD  = 5'd15;
  localparam logic [OpWidth-1:0] CMD_F_W1   = 5'd16;
  localparam logic [OpWidth-1:0] CMD_F_W2   = 5'd17;
  localparam logic [OpWidth-1:0] CMD_F_DONE = 5'd18;

  typedef struct packed {
    logic [OpWidth-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;    // clearing pass at its last entry
    logic out_free;    // output register can take a result this cycle
    logic is_free;     // current transaction is a free
    logic steps_max;   // walk step limit reached
    logic at_oob;      // walk position outside the arena
    logic f_bad;       // free address cannot name a header
    logic sz_zero;     // header read has size zero
    logic rd_used;     // header read is marked used
    logic fit;         // header read is free and large enough
    logic take_whole;  // leftover too small to split
    logic r_oob;       // right neighbor outside the arena
    logic l_stop;      // no left neighbor to look at
  } status_t;

endpackage

[hw/rtl/bta_ram.sv]
// ----------------------------------------------------------------------------
// bta_ram: generic single-write, single-read memory
// One write port and one read port with registered read data that holds
// between reads.
// ----------------------------------------------------------------------------
module bta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bta_datapath.sv]
// ----------------------------------------------------------------------------
// bta_datapath: header store, walk registers and result register
// Executes one command per cycle from the controller and reports status.
// ----------------------------------------------------------------------------
module bta_datapath #(
  parameter int unsigned ARENA_UNITS  = 4096,
  parameter int unsigned HEADER_UNITS = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bta_pkg::cmd_t                  cmd_i,
  output bta_pkg::status_t               status_o,
  input  logic                           func_i,
  input  logic [bta_pkg::FieldWidth-1:0] request_size_i,
  input  logic [bta_pkg::FieldWidth-1:0] free_address_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bta_pkg::FieldWidth-1:0] result_address_o,
  output logic                           alloc_failed_o,
  output logic [bta_pkg::FieldWidth-1:0] high_water_o
);

  localparam int unsigned AW = $clog2(ARENA_UNITS);
  localparam int unsigned VW = ((AW > 13) ? AW : 13) + 2;
  localparam int unsigned CW = $clog2(ARENA_UNITS + 1);
  localparam logic [VW-1:0] AV = VW'(ARENA_UNITS);
  localparam logic [VW-1:0] HV = VW'(HEADER_UNITS);
  localparam logic [AW-1:0] FirstSize = AW'(ARENA_UNITS - HEADER_UNITS);
  localparam logic [CW-1:0] StepMax = CW'(ARENA_UNITS);

  logic [AW-1:0] clr_q, clr_d;
  logic          func_q, fbad_q;
  logic [VW-1:0] need_q, at_q, at_d, osz_q, osz_d, oprev_q, oprev_d;
  logic [CW-1:0] steps_q, steps_d;
  logic [AW-1:0] peak_q;
  logic          out_valid_q;
  logic [bta_pkg::FieldWidth-1:0] res_addr_q;
  logic          failed_q;

  logic          size_we, prev_we, used_we, re;
  logic [AW-1:0] size_wa, prev_wa, used_wa, raddr;
  logic [AW-1:0] size_wd, prev_wd, size_rd, prev_rd;
  logic          used_wd, used_rd;

  logic [VW-1:0] sz_v, prev_v, rest, nxt, mid, rpos, lpos, fend, faddr_v;
  logic          out_free;

  assign sz_v    = VW'(size_rd);
  assign prev_v  = VW'(prev_rd);
  assign rest    = sz_v - need_q;
  assign nxt     = at_q + sz_v;
  assign mid     = at_q + need_q;
  assign rpos    = at_q + osz_q;
  assign lpos    = at_q - oprev_q;
  assign fend    = at_q + osz_q;
  assign faddr_v = VW'(free_address_i);
  assign out_free = !out_valid_q || !out_stall_i;

  bta_ram #(.Width(AW), .Depth(ARENA_UNITS)) u_size_ram (
    .clk_i, .we_i(size_we), .waddr_i(size_wa), .wdata_i(size_wd),
    .re_i(re), .raddr_i(raddr), .rdata_o(size_rd)
  );
  bta_ram #(.Width(AW), .Depth(ARENA_UNITS)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .re_i(re), .raddr_i(raddr), .rdata_o(prev_rd)
  );
  bta_ram #(.Width(1), .Depth(ARENA_UNITS)) u_used_ram (
    .clk_i, .we_i(used_we), .waddr_i(used_wa), .wdata_i(used_wd),
    .re_i(re), .raddr_i(raddr), .rdata_o(used_rd)
  );

  // Read address and memory writes.
  always_comb begin
    re      = 1'b0;
    raddr   = at_q[AW-1:0];
    size_we = 1'b0;
    size_wa = at_q[AW-1:0];
    size_wd = osz_q[AW-1:0];
    prev_we = 1'b0;
    prev_wa = at_q[AW-1:0];
    prev_wd = oprev_q[AW-1:0];
    used_we = 1'b0;
    used_wa = at_q[AW-1:0];
    used_wd = 1'b0;
    case (cmd_i.op)
      bta_pkg::CMD_CLR: begin
        size_we = 1'b1;
        size_wa = clr_q;
        size_wd = (clr_q == '0) ? FirstSize : '0;
        prev_we = 1'b1;
        prev_wa = clr_q;
        prev_wd = (clr_q == FirstSize) ? FirstSize : '0;
        used_we = 1'b1;
        used_wa = clr_q;
      end
      bta_pkg::CMD_RD_AT: re = 1'b1;
      bta_pkg::CMD_RD_R: begin
        re    = 1'b1;
        raddr = rpos[AW-1:0];
      end
      bta_pkg::CMD_RD_L: begin
        re    = 1'b1;
        raddr = lpos[AW-1:0];
      end
      bta_pkg::CMD_A_TAKE: begin
        used_we = 1'b1;
        used_wd = 1'b1;
      end
      bta_pkg::CMD_A_SPL1: begin
        used_we = 1'b1;
        used_wd = 1'b1;
        size_we = 1'b1;
        size_wd = need_q[AW-1:0];
        prev_we = (nxt < AV);
        prev_wa = nxt[AW-1:0];
        prev_wd = rest[AW-1:0];
      end
      bta_pkg::CMD_A_SPL2: begin
        size_we = (mid < AV);
        size_wa = mid[AW-1:0];
        size_wd = rest[AW-1:0];
        prev_we = (mid < AV);
        prev_wa = mid[AW-1:0];
        prev_wd = need_q[AW-1:0];
        used_we = (mid < AV);
        used_wa = mid[AW-1:0];
      end
      bta_pkg::CMD_F_REL: used_we = 1'b1;
      bta_pkg::CMD_F_W1: begin
        prev_we = (fend < AV);
        prev_wa = fend[AW-1:0];
        prev_wd = osz_q[AW-1:0];
        used_we = 1'b1;
        size_we = 1'b1;
      end
      bta_pkg::CMD_F_W2: prev_we = 1'b1;
      default: ;
    endcase
  end

  // Walk registers.
  always_comb begin
    clr_d   = clr_q;
    at_d    = at_q;
    osz_d   = osz_q;
    oprev_d = oprev_q;
    steps_d = steps_q;
    case (cmd_i.op)
      bta_pkg::CMD_CLR:  clr_d = clr_q + AW'(1);
      bta_pkg::CMD_LOAD: begin
        at_d    = func_i ? (faddr_v - HV) : '0;
        steps_d = '0;
      end
      bta_pkg::CMD_A_STEP: begin
        at_d    = nxt;
        steps_d = steps_q + CW'(1);
      end
      bta_pkg::CMD_F_REL: begin
        osz_d   = sz_v;
        oprev_d = prev_v;
        steps_d = '0;
      end
      bta_pkg::CMD_R_ADD: begin
        osz_d   = osz_q + sz_v;
        steps_d = steps_q + CW'(1);
      end
      bta_pkg::CMD_L_INIT: steps_d = '0;
      bta_pkg::CMD_L_ADD: begin
        at_d    = lpos;
        osz_d   = osz_q + sz_v;
        oprev_d = prev_v;
        steps_d = steps_q + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q <= clr_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        bta_pkg::CMD_A_OK: begin
          out_valid_q <= 1'b1;
          if (at_q[AW-1:0] > peak_q) begin
            peak_q <= at_q[AW-1:0];
          end
        end
        bta_pkg::CMD_A_FAIL, bta_pkg::CMD_F_DONE: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    at_q    <= at_d;
    osz_q   <= osz_d;
    oprev_q <= oprev_d;
    steps_q <= steps_d;
    if (cmd_i.op == bta_pkg::CMD_LOAD) begin
      func_q <= func_i;
      need_q <= VW'(request_size_i) + HV;
      fbad_q <= (faddr_v < HV) || ((faddr_v - HV) >= AV);
    end
    case (cmd_i.op)
      bta_pkg::CMD_A_OK: begin
        res_addr_q <= bta_pkg::FieldWidth'(at_q + HV);
        failed_q   <= 1'b0;
      end
      bta_pkg::CMD_A_FAIL: begin
        res_addr_q <= '0;
        failed_q   <= 1'b1;
      end
      bta_pkg::CMD_F_DONE: begin
        res_addr_q <= '0;
        failed_q   <= 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.clr_last   = (clr_q == AW'(ARENA_UNITS - 1));
    status_o.out_free   = out_free;
    status_o.is_free    = func_q;
    status_o.steps_max  = (steps_q == StepMax);
    status_o.at_oob     = (at_q >= AV);
    status_o.f_bad      = fbad_q;
    status_o.sz_zero    = (size_rd == '0);
    status_o.rd_used    = used_rd;
    status_o.fit        = !used_rd && (sz_v >= need_q);
    status_o.take_whole = (rest <= HV);
    status_o.r_oob      = (rpos >= AV);
    status_o.l_stop     = (oprev_q == '0) || (oprev_q > at_q);
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = res_addr_q;
  assign alloc_failed_o   = failed_q;
  assign high_water_o     = bta_pkg::FieldWidth'(peak_q);

endmodule

[hw/rtl/bta_ctrl.sv]
// ----------------------------------------------------------------------------
// bta_ctrl: sequencing state machine of the allocator
// Runs the clearing pass, the first-fit walk and the free merge walks by
// issuing one datapath command per cycle; it waits while the output is stalled.
// ----------------------------------------------------------------------------
module bta_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bta_pkg::status_t  status_i,
  output bta_pkg::cmd_t     cmd_o
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_ARD   = 5'd3;
  localparam logic [4:0] S_ACHK  = 5'd4;
  localparam logic [4:0] S_SPL2  = 5'd5;
  localparam logic [4:0] S_AOK   = 5'd6;
  localparam logic [4:0] S_AFAIL = 5'd7;
  localparam logic [4:0] S_FCHK  = 5'd8;
  localparam logic [4:0] S_FREL  = 5'd9;
  localparam logic [4:0] S_RRD   = 5'd10;
  localparam logic [4:0] S_RCHK  = 5'd11;
  localparam logic [4:0] S_LCHK  = 5'd12;
  localparam logic [4:0] S_LADD  = 5'd13;
  localparam logic [4:0] S_FW1   = 5'd14;
  localparam logic [4:0] S_FW2   = 5'd15;
  localparam logic [4:0] S_FDONE = 5'd16;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = bta_pkg::CMD_NOP;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLR: begin
        cmd_o.op = bta_pkg::CMD_CLR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = bta_pkg::CMD_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: state_d = status_i.is_free ? S_FCHK : S_ARD;
      S_ARD: begin
        if (status_i.steps_max || status_i.at_oob) begin
          state_d = S_AFAIL;
        end else begin
          cmd_o.op = bta_pkg::CMD_RD_AT;
          state_d  = S_ACHK;
        end
      end
      S_ACHK: begin
        if (status_i.sz_zero) begin
          state_d = S_AFAIL;
        end else if (status_i.fit && status_i.take_whole) begin
          cmd_o.op = bta_pkg::CMD_A_TAKE;
          state_d  = S_AOK;
        end else if (status_i.fit) begin
          cmd_o.op = bta_pkg::CMD_A_SPL1;
          state_d  = S_SPL2;
        end else begin
          cmd_o.op = bta_pkg::CMD_A_STEP;
          state_d  = S_ARD;
        end
      end
      S_SPL2: begin
        cmd_o.op = bta_pkg::CMD_A_SPL2;
        state_d  = S_AOK;
      end
      S_AOK: begin
        if (status_i.out_free) begin
          cmd_o.op = bta_pkg::CMD_A_OK;
          state_d  = S_IDLE;
        end
      end
      S_AFAIL: begin
        if (status_i.out_free) begin
          cmd_o.op = bta_pkg::CMD_A_FAIL;
          state_d  = S_IDLE;
        end
      end
      S_FCHK: begin
        if (status_i.f_bad) begin
          state_d = S_FDONE;
        end else begin
          cmd_o.op = bta_pkg::CMD_RD_AT;
          state_d  = S_FREL;
        end
      end
      S_FREL: begin
        if (!status_i.rd_used || status_i.sz_zero) begin
          state_d = S_FDONE;
        end else begin
          cmd_o.op = bta_pkg::CMD_F_REL;
          state_d  = S_RRD;
        end
      end
      S_RRD: begin
        if (status_i.steps_max || status_i.r_oob) begin
          cmd_o.op = bta_pkg::CMD_L_INIT;
          state_d  = S_LCHK;
        end else begin
          cmd_o.op = bta_pkg::CMD_RD_R;
          state_d  = S_RCHK;
        end
      end
      S_RCHK: begin
        if (status_i.rd_used || status_i.sz_zero) begin
          cmd_o.op = bta_pkg::CMD_L_INIT;
          state_d  = S_LCHK;
        end else begin
          cmd_o.op = bta_pkg::CMD_R_ADD;
          state_d  = S_RRD;
        end
      end
      S_LCHK: begin
        if (status_i.steps_max || status_i.l_stop) begin
          state_d = S_FW1;
        end else begin
          cmd_o.op = bta_pkg::CMD_RD_L;
          state_d  = S_LADD;
        end
      end
      S_LADD: begin
        if (status_i.rd_used) begin
          state_d = S_FW1;
        end else begin
          cmd_o.op = bta_pkg::CMD_L_ADD;
          state_d  = S_LCHK;
        end
      end
      S_FW1: begin
        cmd_o.op = bta_pkg::CMD_F_W1;
        state_d  = S_FW2;
      end
      S_FW2: begin
        cmd_o.op = bta_pkg::CMD_F_W2;
        state_d  = S_FDONE;
      end
      S_FDONE: begin
        if (status_i.out_free) begin
          cmd_o.op = bta_pkg::CMD_F_DONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/boundary_tag_first_fit_allocator_top.sv]
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_top: first-fit heap allocator
// Usage:
// The input channel carries one request per transaction: func_i selects
// allocate (0) or free (1), with request_size_i or free_address_i. The
// output channel returns one result per request: the payload offset or a
// failure flag, and the high-water header offset.
// Requests are handled one at a time. An allocate walks the block headers
// in order, reading and checking each one, until it finds a fit or fails,
// and splits the block when the leftover is large enough. A free checks
// the address and reads its header; a used block is merged with free
// right and then free left neighbors. The next request is taken the cycle
// after the result is written. The header store gives one header per
// read, with registered read data. After reset a clearing pass writes
// every entry of the header store, one per cycle; input stays stalled
// meanwhile. A result waits in an output register while out_stall_i is
// high; the next request is then taken but finishes only once that
// register drains.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_top #(
  parameter int unsigned ARENA_UNITS  = 4096,
  parameter int unsigned HEADER_UNITS = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [bta_pkg::FieldWidth-1:0] request_size_i,
  input  logic [bta_pkg::FieldWidth-1:0] free_address_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bta_pkg::FieldWidth-1:0] result_address_o,
  output logic                           alloc_failed_o,
  output logic [bta_pkg::FieldWidth-1:0] high_water_o
);

  bta_pkg::cmd_t    cmd;
  bta_pkg::status_t status;

  bta_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .status_i(status), .cmd_o(cmd)
  );

  bta_datapath #(
    .ARENA_UNITS(ARENA_UNITS), .HEADER_UNITS(HEADER_UNITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .func_i, .request_size_i, .free_address_i,
    .out_valid_o, .out_stall_i, .result_address_o, .alloc_failed_o,
    .high_water_o
  );

  // A failed allocate never reports an address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alloc_failed_o |-> result_address_o == '0)
    else $error("failed allocate carries an address");

  // The block is busy in the cycle after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // The high-water mark never decreases.
  a_peak_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> high_water_o >= $past(high_water_o))
    else $error("high-water mark decreased");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the first-fit heap allocator
// Drives allocate and free requests under random idling on both channels,
// predicts each result with a software copy of the heap, and compares every
// result field by field in order.
// ----------------------------------------------------------------------------

class heap_scoreboard;
  localparam int ArenaUnits  = 4096;
  localparam int HeaderUnits = 1;
  localparam logic OpAlloc = 1'b0;

  int unsigned blk_size[ArenaUnits];
  int unsigned blk_prev[ArenaUnits];
  bit          blk_used[ArenaUnits];
  int unsigned peak;
  bit          failed;
  logic [11:0] exp_addr_q[$];
  logic        exp_fail_q[$];
  logic [11:0] exp_peak_q[$];
  // Payload offsets that are currently allocated.
  int unsigned live_q[$];

  function new();
    int unsigned first;
    first = ArenaUnits - HeaderUnits;
    foreach (blk_size[i]) begin
      blk_size[i] = 0;
      blk_prev[i] = 0;
      blk_used[i] = 0;
    end
    blk_size[0] = first;
    blk_prev[first] = first;
    peak = 0;
    failed = 0;
  endfunction

  function bit find_fit(int unsigned need, output int unsigned hdr);
    int unsigned at, sz, rest;
    at = 0;
    hdr = 0;
    for (int unsigned s = 0; s < ArenaUnits; s++) begin
      if (at >= ArenaUnits) return 0;
      sz = blk_size[at];
      if (sz == 0) return 0;
      if (!blk_used[at] && sz >= need) begin
        rest = sz - need;
        blk_used[at] = 1;
        if (rest > HeaderUnits) begin
          if (at + sz < ArenaUnits) blk_prev[at + sz] = rest;
          if (at + need < ArenaUnits) begin
            blk_size[at + need] = rest;
            blk_prev[at + need] = need;
            blk_used[at + need] = 0;
          end
          blk_size[at] = need;
        end
        hdr = at;
        return 1;
      end
      at += sz;
    end
    return 0;
  endfunction

  function void release_block(int unsigned addr);
    int unsigned at, sz, prv, r, l;
    if (addr < HeaderUnits) return;
    at = addr - HeaderUnits;
    if (at >= ArenaUnits || !blk_used[at] || blk_size[at] == 0) return;
    blk_used[at] = 0;
    sz = blk_size[at];
    prv = blk_prev[at];
    for (int unsigned s = 0; s < ArenaUnits; s++) begin
      r = at + sz;
      if (r >= ArenaUnits || blk_used[r] || blk_size[r] == 0) break;
      sz += blk_size[r];
    end
    for (int unsigned s = 0; s < ArenaUnits; s++) begin
      if (prv == 0 || prv > at) break;
      l = at - prv;
      if (blk_used[l]) break;
      sz += blk_size[l];
      prv = blk_prev[l];
      at = l;
    end
    if (at + sz < ArenaUnits) blk_prev[at + sz] = sz;
    blk_used[at] = 0;
    blk_size[at] = sz;
    blk_prev[at] = prv;
  endfunction

  function void note_request(logic op, logic [11:0] req, logic [11:0] faddr);
    int unsigned hdr;
    logic [11:0] addr;
    logic        fl;
    addr = '0;
    fl = 1'b0;
    if (op == OpAlloc) begin
      if (find_fit(req + HeaderUnits, hdr)) begin
        if (hdr > peak) peak = hdr;
        addr = 12'(hdr + HeaderUnits);
        live_q.push_back(hdr + HeaderUnits);
      end else begin
        fl = 1'b1;
      end
    end else begin
      foreach (live_q[i]) begin
        if (live_q[i] == faddr) begin
          live_q.delete(i);
          break;
        end
      end
      release_block(faddr);
    end
    exp_addr_q.push_back(addr);
    exp_fail_q.push_back(fl);
    exp_peak_q.push_back(peak[11:0]);
  endfunction

  function void check_result(logic [11:0] addr, logic fl, logic [11:0] hw);
    logic [11:0] ea, eh;
    logic        ef;
    if (exp_addr_q.size() == 0) begin
      $display("%0t: unexpected result addr=%0d", $time, addr);
      failed = 1;
      return;
    end
    ea = exp_addr_q.pop_front();
    ef = exp_fail_q.pop_front();
    eh = exp_peak_q.pop_front();
    if (addr !== ea) begin
      $display("%0t: result_address expected %0d actual %0d", $time, ea, addr);
      failed = 1;
    end
    if (fl !== ef) begin
      $display("%0t: alloc_failed expected %0d actual %0d", $time, ef, fl);
      failed = 1;
    end
    if (hw !== eh) begin
      $display("%0t: high_water expected %0d actual %0d", $time, eh, hw);
      failed = 1;
    end
  endfunction

  function int pending();
    return exp_addr_q.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;
  localparam int   CycleLimit = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [11:0] request_size_i = '0;
  logic [11:0] free_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [11:0] result_address_o;
  logic        alloc_failed_o;
  logic [11:0] high_water_o;

  heap_scoreboard heap = new();
  int unsigned in_idle_pct = 21;
  int unsigned out_stall_pct = 60;
  int unsigned cycle_cnt = 0;

  boundary_tag_first_fit_allocator_top dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: compare on each accepted transaction, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        heap.check_result(result_address_o, alloc_failed_o, high_water_o);
      out_stall_i <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Valid stays high from one transaction to the next unless the sender idles.
  task automatic send_request(logic op, logic [11:0] req, logic [11:0] faddr);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i     <= 1'b1;
    func_i         <= op;
    request_size_i <= req;
    free_address_i <= faddr;
    do @(posedge clk_i); while (in_stall_o);
    heap.note_request(op, req, faddr);
  endtask

  task automatic random_request();
    int unsigned pick, idx;
    logic [11:0] req;
    pick = $urandom_range(99);
    if (pick < 3) begin
      // Free at the first or the last offset; the first never names a header.
      send_request(OpFree, 12'($urandom), $urandom_range(0, 1) ? 12'd0 : 12'hFFF);
    end else if (heap.live_q.size() > 0 && pick < 50) begin
      idx = $urandom_range(heap.live_q.size() - 1);
      send_request(OpFree, 12'($urandom), 12'(heap.live_q[idx]));
    end else begin
      if ($urandom_range(99) < 4) req = 12'($urandom);
      else req = 12'($urandom_range(0, 200));
      send_request(OpAlloc, req, 12'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: zero, odd and maximum sizes, exact fit, double free.
    send_request(OpAlloc, 12'd0, 12'hFFF);
    send_request(OpAlloc, 12'hFFF, 12'h000);
    send_request(OpAlloc, 12'd5, 12'h000);
    send_request(OpAlloc, 12'd1, 12'h000);
    send_request(OpAlloc, 12'd7, 12'h000);
    send_request(OpFree, 12'h000, 12'd3);
    send_request(OpFree, 12'h000, 12'd3);
    send_request(OpFree, 12'hFFF, 12'd0);
    send_request(OpAlloc, 12'd5, 12'h000);
    send_request(OpFree, 12'h000, 12'd1);
    send_request(OpFree, 12'h000, 12'd9);
    send_request(OpFree, 12'h000, 12'd3);
    send_request(OpAlloc, 12'd4093, 12'h000);
    send_request(OpAlloc, 12'd4094, 12'h000);
    send_request(OpAlloc, 12'd0, 12'h000);
    while (heap.live_q.size() > 0) send_request(OpFree, 12'h000, 12'(heap.live_q[0]));
    send_request(OpAlloc, 12'd4094, 12'h000);
    send_request(OpFree, 12'h000, 12'd1);
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct   = (ph == 0) ? 21 : (ph == 1) ? 60 : 0;
      out_stall_pct = (ph == 0) ? 60 : (ph == 1) ? 21 : 0;
      for (int i = 0; i < 430; i++) random_request();
    end
    in_valid_i <= 1'b0;
    while (heap.pending() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!heap.failed && heap.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/bta_pkg.sv
hw/rtl/bta_ram.sv
hw/rtl/bta_datapath.sv
hw/rtl/bta_ctrl.sv
hw/rtl/boundary_tag_first_fit_allocator_top.sv
sim/tb_top.sv
